// ===== design/deq_pkg.sv =====
`timescale 1ns / 1ps

package deq_pkg;

  // Command codes carried by each input word
  typedef enum logic [1:0] {
    CMD_PUSH_BACK  = 2'd0,
    CMD_POP_BACK   = 2'd1,
    CMD_PUSH_FRONT = 2'd2,
    CMD_POP_FRONT  = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    push_back;
    logic    push_front;
    logic    pop_back;
    logic    pop_front;
    status_t status;
  } dp_ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

// ===== design/deq_ram.sv =====
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/deq_ctrl.sv =====
`timescale 1ns / 1ps

module deq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_command,
  output logic              out_valid,
  input  logic              out_stall,
  input  deq_pkg::dp_stat_t stat_i,
  output deq_pkg::dp_ctrl_t ctrl_o
);

  import deq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    ctrl_o    = '0;
    ctrl_o.status = ST_DONE;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl_o.load = 1'b1;
          state_nxt   = S_OUT;
          unique case (cmd_t'(in_command))
            CMD_PUSH_BACK: begin
              if (stat_i.full) ctrl_o.status = ST_FULL;
              else ctrl_o.push_back = 1'b1;
            end
            CMD_PUSH_FRONT: begin
              if (stat_i.full) ctrl_o.status = ST_FULL;
              else ctrl_o.push_front = 1'b1;
            end
            CMD_POP_BACK: begin
              if (stat_i.empty) ctrl_o.status = ST_EMPTY;
              else ctrl_o.pop_back = 1'b1;
            end
            CMD_POP_FRONT: begin
              if (stat_i.empty) ctrl_o.status = ST_EMPTY;
              else ctrl_o.pop_front = 1'b1;
            end
          endcase
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = S_IDLE;
      end
    endcase
  end

  // at most one datapath operation per word
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctrl_o.push_back, ctrl_o.push_front, ctrl_o.pop_back, ctrl_o.pop_front}))
    else $error("more than one deque operation issued");

  // a loaded word always shows a result next cycle
  a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_o.load |=> out_valid)
    else $error("result not presented after load");

endmodule

// ===== design/deq_dpath.sv =====
`timescale 1ns / 1ps

module deq_dpath #(
  parameter int CAPACITY = 16,
  localparam int LEN_W = $clog2(CAPACITY + 1),
  localparam int IDX_W = $clog2(CAPACITY)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  deq_pkg::dp_ctrl_t  ctrl_i,
  output deq_pkg::dp_stat_t  stat_o,
  input  logic signed [31:0] in_push_value,
  output logic signed [31:0] out_pop_value,
  output logic [1:0]         out_status,
  output logic [LEN_W-1:0]   out_length
);

  import deq_pkg::*;

  localparam int SUM_W = LEN_W + 1;

  logic [IDX_W-1:0] front_r, front_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0] cnt_m1;
  logic [SUM_W-1:0] ring_sum;
  logic [IDX_W-1:0] ring_addr;
  logic [IDX_W-1:0] front_dec, front_inc;
  logic [IDX_W-1:0] waddr, raddr;
  logic             ram_we, ram_re;
  logic [31:0]      rdata;
  status_t          status_r;
  logic [LEN_W-1:0] length_r;
  logic             pop_ok_r;

  assign stat_o.full  = (count_r == LEN_W'(CAPACITY));
  assign stat_o.empty = (count_r == '0);

  // back slot: front + count (push) or front + count - 1 (pop), wrapped
  assign cnt_m1    = count_r - 1'b1;
  assign ring_sum  = SUM_W'(front_r) + (ctrl_i.pop_back ? SUM_W'(cnt_m1) : SUM_W'(count_r));
  assign ring_addr = (ring_sum >= SUM_W'(CAPACITY)) ? IDX_W'(ring_sum - SUM_W'(CAPACITY))
                                                    : IDX_W'(ring_sum);
  assign front_dec = (front_r == '0) ? IDX_W'(CAPACITY - 1) : front_r - 1'b1;
  assign front_inc = (front_r == IDX_W'(CAPACITY - 1)) ? '0 : front_r + 1'b1;

  // store access
  assign ram_we = ctrl_i.push_back | ctrl_i.push_front;
  assign ram_re = ctrl_i.pop_back | ctrl_i.pop_front;
  assign waddr  = ctrl_i.push_back ? ring_addr : front_dec;
  assign raddr  = ctrl_i.pop_back ? ring_addr : front_r;

  deq_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_push_value),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // front index and count update
  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    if (ctrl_i.push_back) begin
      count_nxt = count_r + 1'b1;
    end else if (ctrl_i.push_front) begin
      front_nxt = front_dec;
      count_nxt = count_r + 1'b1;
    end else if (ctrl_i.pop_back) begin
      count_nxt = cnt_m1;
    end else if (ctrl_i.pop_front) begin
      front_nxt = front_inc;
      count_nxt = cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // result word; popped data comes from the RAM read register
  always_ff @(posedge clk) begin
    if (ctrl_i.load) begin
      status_r <= ctrl_i.status;
      length_r <= count_nxt;
      pop_ok_r <= ram_re;
    end
  end

  assign out_pop_value = pop_ok_r ? $signed(rdata) : 32'sd0;
  assign out_status    = status_r;
  assign out_length    = length_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LEN_W'(CAPACITY))
    else $error("entry count above capacity");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_i.push_back || ctrl_i.push_front) |=> count_r == LEN_W'($past(count_r) + 1'b1))
    else $error("push did not grow the queue by one");

endmodule

// ===== design/double_ended_queue.sv =====
`timescale 1ns / 1ps
// Double-ended queue of signed 32-bit words held in a ring store of CAPACITY
// entries, tracked by a front index and an entry count.
// Input channel (in_valid / in_stall): each word is a command (push back, pop
// back, push front, pop front) plus a value used by pushes.
// Result channel (out_valid / out_stall): one word per command with the popped
// value (zero unless a pop succeeded), a status (done, pop on empty, push on
// full) and the queue length after the command.
// Latency: the result is valid the cycle after the command is accepted; the
// ring address and the store access happen in the accept cycle, the popped
// data comes from the RAM read register.
// Commands do not overlap: the controller takes a new command only once the
// previous result has been taken.
// While the receiver stalls, the result holds and in_stall stays high.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; store contents are not cleared and need no clearing pass.
// Pop on empty and push on full leave the queue unchanged.

module double_ended_queue #(
  parameter int CAPACITY = 16,
  localparam int LEN_W = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic signed [31:0] in_push_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pop_value,
  output logic [1:0]         out_status,
  output logic [LEN_W-1:0]   out_length
);

  import deq_pkg::*;

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  deq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .in_push_value (in_push_value),
    .out_pop_value (out_pop_value),
    .out_status    (out_status),
    .out_length    (out_length)
  );

endmodule
